// ===== hw/rtl/pid_pkg.sv =====
// ---------------------------------------------------------------------------
// PID controller package
// Widths, register indices, item types and status types shared by the
// controller top level and its arithmetic units.
// ---------------------------------------------------------------------------
package pid_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int GAIN_W    = 16;
  localparam int TICK_W    = 16;
  localparam int OUT_W     = 24;
  localparam int CFG_IDX_W = 2;

  // error is one bit wider than a sample, the error step one more
  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int DIFF_W = SAMPLE_WIDTH + 2;

  // shared multiplier: gain magnitude times error, step or tick magnitude
  localparam int MUL_A_W = GAIN_W;
  localparam int MUL_B_W = (SAMPLE_WIDTH + 1 > TICK_W) ? SAMPLE_WIDTH + 1 : TICK_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // divider numerator holds a product plus half the divisor
  localparam int DIV_NUM_W = ((MUL_P_W > 32) ? MUL_P_W : 32) + 1;
  localparam int DIV_QUO_W = OUT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 16'sd256;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] setpoint;
    logic signed [SAMPLE_WIDTH-1:0] measurement;
    logic        [TICK_W-1:0]       elapsed_ticks;
  } pid_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic signed [OUT_W-1:0] term_proportional;
    logic signed [OUT_W-1:0] term_integral;
    logic signed [OUT_W-1:0] term_derivative;
    logic                    saturated;
    logic                    zero_interval;
  } pid_out_t;

  typedef struct packed {
    logic done;
    logic overflow;
  } pid_div_stat_t;

endpackage

// ===== hw/rtl/pid_mul.sv =====
// ---------------------------------------------------------------------------
// PID shared multiplier
// Unsigned magnitude multiplier with a registered product, reused by the
// sequencer for every product of a control step.
// ---------------------------------------------------------------------------
module pid_mul #(
  parameter int AWidth = pid_pkg::MUL_A_W,
  parameter int BWidth = pid_pkg::MUL_B_W
) (
  input  logic                     clk,
  input  logic [AWidth-1:0]        a,
  input  logic [BWidth-1:0]        b,
  output logic [AWidth+BWidth-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= {{BWidth{1'b0}}, a} * {{AWidth{1'b0}}, b};
  end

endmodule

// ===== hw/rtl/pid_div.sv =====
// ---------------------------------------------------------------------------
// PID derivative divider
// Restoring divider, one quotient bit per cycle. Quotients that would not
// fit the result width are flagged at start and take no steps.
// ---------------------------------------------------------------------------
module pid_div #(
  parameter int NumW = pid_pkg::DIV_NUM_W,
  parameter int DenW = pid_pkg::TICK_W,
  parameter int QuoW = pid_pkg::DIV_QUO_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NumW-1:0]       num,
  input  logic [DenW-1:0]       den,
  output logic [QuoW-1:0]       quo,
  output pid_pkg::pid_div_stat_t stat
);

  localparam int HiW  = NumW - QuoW;
  localparam int CmpW = (HiW > DenW) ? HiW : DenW;
  localparam int CntW = $clog2(QuoW + 1);

  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem;
  logic [QuoW-1:0] work;
  logic [CntW-1:0] count;
  logic            active;
  logic            done;
  logic            ovf;

  logic [HiW-1:0]  hi;
  logic            too_big;
  logic [DenW:0]   sh;
  logic [DenW:0]   sub;
  logic            ge;
  logic [DenW-1:0] rem_step;

  always_comb begin
    hi       = num[NumW-1:QuoW];
    too_big  = CmpW'(hi) >= CmpW'(den);
    sh       = {rem, work[QuoW-1]};
    sub      = sh - {1'b0, den_q};
    ge       = sh >= {1'b0, den_q};
    rem_step = ge ? sub[DenW-1:0] : sh[DenW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      ovf    <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ovf <= too_big;
        if (too_big) begin
          done   <= 1'b1;
          active <= 1'b0;
        end else begin
          active <= 1'b1;
          count  <= CntW'(QuoW);
        end
      end else if (active) begin
        count <= count - CntW'(1);
        if (count == CntW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // high part is below the divisor when the quotient fits, so it seeds rem
  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      rem   <= DenW'(hi);
      work  <= num[QuoW-1:0];
    end else if (active) begin
      rem  <= rem_step;
      work <= {work[QuoW-2:0], ge};
    end
  end

  assign quo           = work;
  assign stat.done     = done;
  assign stat.overflow = ovf;

endmodule

// ===== hw/rtl/pid_controller_top.sv =====
// ---------------------------------------------------------------------------
// PID controller top level
// Parallel-form PID step: proportional, integral and derivative terms from
// one setpoint/measurement item, with a kept integral and previous error.
// ---------------------------------------------------------------------------
// One item is worked on at a time. An accepted item passes through the
// sequencing states MP, MGI, MLO, MHI, ACC, INC and INT, the restoring
// divider for the derivative (24 quotient steps; skipped when elapsed_ticks
// is zero, no steps when the quotient would not fit and is clipped) and the
// DRV state that sums the drive; the next item can be taken once the result
// is loaded. The sequencing states make five passes through the shared
// multiplier and fold the integral. A finished result waits in the output
// register while the next item is accepted; a result still held there only
// delays the last step. Gains are signed Q8.8 and are to be written by the
// user only while the block is idle; the block itself does not enforce it.
// Terms, integral and drive clip at the 24-bit range and raise saturated;
// rounding is to nearest with ties away from zero.
module pid_controller_top #(
  parameter int FracBits = pid_pkg::GAIN_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  pid_pkg::pid_in_t                sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output pid_pkg::pid_out_t               result,
  input  logic                            cfg_write,
  input  logic [pid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pid_pkg::GAIN_W-1:0]      cfg_data
);

  import pid_pkg::*;

  localparam int AccW  = SAMPLE_WIDTH + 32;
  localparam int IncRW = (AccW + 1 > 42) ? AccW + 1 : 42;
  localparam int IncW  = 41;
  localparam int SumW  = 43;
  localparam int MagW  = MUL_P_W + 1;
  localparam int DrvW  = OUT_W + 2;
  localparam int HALF_F = (1 << FracBits) >> 1;

  localparam logic [IncRW-1:0] INC_LIMIT = {{(IncRW-41){1'b0}}, 1'b1, 40'b0};
  localparam logic [MagW-1:0]  MAG_POS_LIM = MagW'((1 << (OUT_W-1)) - 1);
  localparam logic [MagW-1:0]  MAG_NEG_LIM = MagW'(1 << (OUT_W-1));

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MP   = 11'b000_0000_0010,
    S_MGI  = 11'b000_0000_0100,
    S_MLO  = 11'b000_0000_1000,
    S_MHI  = 11'b000_0001_0000,
    S_ACC  = 11'b000_0010_0000,
    S_INC  = 11'b000_0100_0000,
    S_INT  = 11'b000_1000_0000,
    S_DIV  = 11'b001_0000_0000,
    S_DRV  = 11'b010_0000_0000,
    S_HOLD = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] val;
    logic                    hit;
  } clip_t;

  // signed value from a magnitude and sign, clipped to the output range
  function automatic clip_t clip_mag(input logic [MagW-1:0] m, input logic neg);
    clip_t r;
    r.hit = 1'b0;
    if (neg) begin
      if (m > MAG_NEG_LIM) begin
        r.val = OUT_MIN;
        r.hit = 1'b1;
      end else begin
        r.val = -signed'(m[OUT_W-1:0]);
      end
    end else begin
      if (m > MAG_POS_LIM) begin
        r.val = OUT_MAX;
        r.hit = 1'b1;
      end else begin
        r.val = signed'(m[OUT_W-1:0]);
      end
    end
    return r;
  endfunction

  state_t state, state_next;

  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic signed [OUT_W-1:0]  integral, term_p, term_d;
  logic signed [ERR_W-1:0]  prev_err, err;
  logic signed [DIFF_W-1:0] diff;
  logic [TICK_W-1:0]        dt;
  logic                     zero, sat;

  logic [MUL_A_W-1:0]   gidt_hi, mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   prod;
  logic [AccW-1:0]      acc;
  logic [IncW-1:0]      inc_mag;
  logic [DIV_NUM_W-1:0] dnum;
  logic [DIV_QUO_W-1:0] div_quo;
  pid_div_stat_t        div_stat;
  logic                 div_start;

  logic                     take, load;
  logic signed [ERR_W-1:0]  err_calc;
  logic signed [DIFF_W-1:0] diff_calc;
  logic [GAIN_W-1:0]        gp_mag, gi_mag, gd_mag;
  logic [SAMPLE_WIDTH-1:0]  err_mag;
  logic [DIFF_W-2:0]        diff_mag;
  logic                     p_neg, i_neg, d_neg;
  logic [MagW-1:0]          p_round;
  clip_t                    p_clip, d_clip, int_clip, drv_clip;
  logic [IncRW-1:0]         inc_round;
  logic [DIV_NUM_W-1:0]     half_den, dnum_calc;
  logic signed [SumW-1:0]   inc_s, int_sum;
  logic signed [DrvW-1:0]   drv_sum;

  assign take         = sample_valid && !sample_stall;
  assign sample_stall = rst || (state != S_IDLE);
  assign load         = (state == S_DRV || state == S_HOLD) && (!result_valid || !result_stall);
  assign div_start    = (state == S_INT) && !zero;

  always_comb begin
    err_calc  = ERR_W'(sample.setpoint) - ERR_W'(sample.measurement);
    diff_calc = DIFF_W'(err_calc) - DIFF_W'(prev_err);

    gp_mag   = gain_p[GAIN_W-1] ? GAIN_W'(-gain_p) : GAIN_W'(gain_p);
    gi_mag   = gain_i[GAIN_W-1] ? GAIN_W'(-gain_i) : GAIN_W'(gain_i);
    gd_mag   = gain_d[GAIN_W-1] ? GAIN_W'(-gain_d) : GAIN_W'(gain_d);
    err_mag  = err[ERR_W-1] ? SAMPLE_WIDTH'(-err) : SAMPLE_WIDTH'(err);
    diff_mag = diff[DIFF_W-1] ? (DIFF_W-1)'(-diff) : (DIFF_W-1)'(diff);
    p_neg    = gain_p[GAIN_W-1] ^ err[ERR_W-1];
    i_neg    = gain_i[GAIN_W-1] ^ err[ERR_W-1];
    d_neg    = gain_d[GAIN_W-1] ^ diff[DIFF_W-1];

    p_round = (MagW'(prod) + MagW'(HALF_F)) >> FracBits;
    p_clip  = clip_mag(p_round, p_neg);

    inc_round = (IncRW'(acc) + IncRW'(HALF_F)) >> FracBits;

    half_den  = (DIV_NUM_W'(dt) << FracBits) >> 1;
    dnum_calc = (DIV_NUM_W'(prod) + half_den) >> FracBits;

    inc_s   = i_neg ? -signed'(SumW'(inc_mag)) : signed'(SumW'(inc_mag));
    int_sum = SumW'(integral) + inc_s;
    int_clip.hit = 1'b0;
    if (int_sum > SumW'(OUT_MAX)) begin
      int_clip.val = OUT_MAX;
      int_clip.hit = 1'b1;
    end else if (int_sum < SumW'(OUT_MIN)) begin
      int_clip.val = OUT_MIN;
      int_clip.hit = 1'b1;
    end else begin
      int_clip.val = int_sum[OUT_W-1:0];
    end

    d_clip = clip_mag(MagW'({div_stat.overflow, div_quo}), d_neg);

    drv_sum = DrvW'(term_p) + DrvW'(integral) + DrvW'(term_d);
    drv_clip.hit = 1'b0;
    if (drv_sum > DrvW'(OUT_MAX)) begin
      drv_clip.val = OUT_MAX;
      drv_clip.hit = 1'b1;
    end else if (drv_sum < DrvW'(OUT_MIN)) begin
      drv_clip.val = OUT_MIN;
      drv_clip.hit = 1'b1;
    end else begin
      drv_clip.val = drv_sum[OUT_W-1:0];
    end
  end

  // multiplier operands; the product is registered and shows in the next state
  always_comb begin
    unique case (state)
      S_MP: begin
        mul_a = gp_mag;
        mul_b = MUL_B_W'(err_mag);
      end
      S_MGI: begin
        mul_a = gi_mag;
        mul_b = MUL_B_W'(dt);
      end
      S_MLO: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(err_mag);
      end
      S_MHI: begin
        mul_a = gidt_hi;
        mul_b = MUL_B_W'(err_mag);
      end
      default: begin
        mul_a = gd_mag;
        mul_b = MUL_B_W'(diff_mag);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (take) state_next = S_MP;
      S_MP:   state_next = S_MGI;
      S_MGI:  state_next = S_MLO;
      S_MLO:  state_next = S_MHI;
      S_MHI:  state_next = S_ACC;
      S_ACC:  state_next = S_INC;
      S_INC:  state_next = S_INT;
      S_INT:  state_next = zero ? S_DRV : S_DIV;
      S_DIV:  if (div_stat.done) state_next = S_DRV;
      S_DRV:  state_next = load ? S_IDLE : S_HOLD;
      S_HOLD: if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      gain_p       <= GAIN_P_RESET;
      gain_i       <= '0;
      gain_d       <= '0;
      integral     <= '0;
      prev_err     <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_GAIN_P: gain_p <= signed'(cfg_data);
          CFG_GAIN_I: gain_i <= signed'(cfg_data);
          CFG_GAIN_D: gain_d <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (take) begin
        prev_err <= err_calc;
      end
      if (state == S_INT) begin
        integral <= int_clip.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (take) begin
          err  <= err_calc;
          diff <= diff_calc;
          dt   <= sample.elapsed_ticks;
          zero <= (sample.elapsed_ticks == '0);
          sat  <= 1'b0;
        end
      end
      S_MGI: begin
        term_p <= p_clip.val;
        sat    <= sat | p_clip.hit;
      end
      S_MLO: gidt_hi <= prod[2*MUL_A_W-1:MUL_A_W];
      S_MHI: acc <= AccW'(prod);
      S_ACC: acc <= acc + (AccW'(prod) << MUL_A_W);
      S_INC: begin
        dnum <= dnum_calc;
        if (inc_round > INC_LIMIT) begin
          inc_mag <= IncW'(INC_LIMIT);
          sat     <= 1'b1;
        end else begin
          inc_mag <= IncW'(inc_round);
        end
      end
      S_INT: begin
        sat <= sat | int_clip.hit;
        if (zero) term_d <= '0;
      end
      S_DIV: begin
        if (div_stat.done) begin
          term_d <= d_clip.val;
          sat    <= sat | d_clip.hit;
        end
      end
      S_DRV, S_HOLD: begin
        if (load) begin
          result.drive             <= drv_clip.val;
          result.term_proportional <= term_p;
          result.term_integral     <= integral;
          result.term_derivative   <= term_d;
          result.saturated         <= sat | drv_clip.hit;
          result.zero_interval     <= zero;
        end
      end
      default: ;
    endcase
  end

  pid_mul #(
    .AWidth(MUL_A_W),
    .BWidth(MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pid_div #(
    .NumW(DIV_NUM_W),
    .DenW(TICK_W),
    .QuoW(DIV_QUO_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (dt),
    .quo   (div_quo),
    .stat  (div_stat)
  );

endmodule
